### sv/ptd_pkg.sv
package ptd_pkg;

    localparam int MAX_TASKS    = 8;
    localparam int RESULT_LIMIT = 8;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int REP_W = $clog2(RESULT_LIMIT + 1);

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_POLL  = 2'd2;

    localparam logic [2:0] KIND_ADDED   = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_CLEARED = 3'd2;
    localparam logic [2:0] KIND_DUE     = 3'd3;
    localparam logic [2:0] KIND_NONE    = 3'd4;

endpackage

### sv/periodic_task_dispatcher.sv
// Clear/add items: accept, then load of the one result; poll items: accept, then per task
// a RAM read, then subtract and compare on the shared 32-bit unit, and a closing step;
// an item takes longer while the output stalls.
// The next item is accepted once the last result of the previous one sits in the
// output register, which may still be waiting for the receiver.
// rst_n async, active low: count, active marks and control cleared; RAMs keep their data.
module periodic_task_dispatcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] period_ms, [63:32] now_ms
    input  logic [1:0]  s_axis_tuser,  // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [2:0] task_index, [7:3] zero
    output logic [2:0]  m_axis_tuser,  // [2:0] result_kind
    output logic        m_axis_tlast   // last result of the item
);

    import ptd_pkg::*;

    // sequencer codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SINGLE = 3'd1;  // clear/add result waits for output
    localparam logic [2:0] S_FETCH  = 3'd2;  // RAM read of task idx issued
    localparam logic [2:0] S_EVAL   = 3'd3;  // elapsed time compared with period
    localparam logic [2:0] S_FINISH = 3'd4;  // closing result of a poll

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [MAX_TASKS-1:0] active_reg, active_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [REP_W-1:0]     rep_reg, rep_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [2:0]           res_kind_reg, res_kind_next;
    logic [31:0]          now_reg, now_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           out_kind_reg, out_kind_next;
    logic [2:0]           out_idx_reg, out_idx_next;
    logic                 out_last_reg, out_last_next;

    // RAM ports
    logic                 per_we;
    logic                 lr_we;
    logic [IDX_W-1:0]     waddr;
    logic [31:0]          lr_wdata;
    logic [31:0]          period_rd;
    logic [31:0]          last_run_rd;

    logic                 in_accept;
    logic                 out_free;
    logic [31:0]          elapsed;
    logic                 due;
    logic                 report;
    logic                 advance;
    logic                 last_task;
    logic [1:0]           action;
    logic [31:0]          period_in;

    assign action    = s_axis_tuser;
    assign period_in = s_axis_tdata[31:0];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // shared unit: wrapped elapsed time and compare against period
    assign elapsed   = now_reg - last_run_rd;
    assign due       = active_reg[idx_reg] && (elapsed >= period_rd);
    assign report    = due && (rep_reg < REP_W'(RESULT_LIMIT));
    // a second due task pushes the held one out, which needs a free output
    assign advance   = !(report && pend_valid_reg && !out_free);
    assign last_task = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        active_next     = active_reg;
        idx_next        = idx_reg;
        rep_next        = rep_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        res_kind_next   = res_kind_reg;
        now_next        = now_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        per_we          = 1'b0;
        lr_we           = 1'b0;
        waddr           = idx_reg;
        lr_wdata        = now_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    now_next = s_axis_tdata[63:32];
                    case (action)
                        ACT_CLEAR:
                        begin
                            count_next    = '0;
                            active_next   = '0;
                            res_kind_next = KIND_CLEARED;
                            pend_idx_next = '0;
                            state_next    = S_SINGLE;
                        end
                        ACT_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_TASKS))
                            begin
                                res_kind_next = KIND_FULL;
                                pend_idx_next = '0;
                            end
                            else
                            begin
                                waddr                = count_reg[IDX_W-1:0];
                                per_we               = 1'b1;
                                lr_we                = 1'b1;
                                lr_wdata             = '0;
                                active_next[waddr]   = 1'b1;
                                count_next           = count_reg + CNT_W'(1);
                                res_kind_next        = KIND_ADDED;
                                pend_idx_next        = count_reg[IDX_W-1:0];
                            end
                            state_next = S_SINGLE;
                        end
                        ACT_POLL:
                        begin
                            idx_next        = '0;
                            rep_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = (count_reg == '0) ? S_FINISH : S_FETCH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;  // undefined action: dropped
                        end
                    endcase
                end
            end
            S_SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_idx_next   = 3'(pend_idx_reg);
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_FETCH:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (advance)
                begin
                    lr_we = due;
                    if (report)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_DUE;
                            out_idx_next   = 3'(pend_idx_reg);
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = idx_reg;
                        rep_next        = rep_reg + REP_W'(1);
                    end
                    if (last_task)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_FETCH;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_valid_reg ? KIND_DUE : KIND_NONE;
                    out_idx_next    = pend_valid_reg ? 3'(pend_idx_reg) : 3'd0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            rep_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
            rep_reg        <= rep_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        res_kind_reg <= res_kind_next;
        now_reg      <= now_next;
        out_kind_reg <= out_kind_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    ptd_ram #(
        .WIDTH (32),
        .DEPTH (MAX_TASKS)
    ) u_period_ram (
        .clk   (clk),
        .we    (per_we),
        .waddr (waddr),
        .wdata (period_in),
        .raddr (idx_reg),
        .rdata (period_rd)
    );

    ptd_ram #(
        .WIDTH (32),
        .DEPTH (MAX_TASKS)
    ) u_last_run_ram (
        .clk   (clk),
        .we    (lr_we),
        .waddr (waddr),
        .wdata (lr_wdata),
        .raddr (idx_reg),
        .rdata (last_run_rd)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_idx_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // no held due task outside a poll
    a_pend_in_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_SINGLE) |-> !pend_valid_reg)
        else $error("held due task outside a poll");

    // table never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("task count beyond capacity");

    // a held output must not be overwritten by the sequencer
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready && state_reg == S_EVAL && report
         && pend_valid_reg) |=> $stable(out_idx_reg) && (state_reg == S_EVAL))
        else $error("pending result overwritten");

    // reported due count stays within the result limit
    a_rep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rep_reg <= REP_W'(RESULT_LIMIT))
        else $error("too many due results");

endmodule

### sv/ptd_ram.sv
module ptd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
